/* design/pwm_duty_threshold_debounce_defines.svh */
// -----------------------------------------------------------------------------
// PWM duty threshold debounce assertion macros
// Shared concurrent assertion wrappers for the checker file.
// -----------------------------------------------------------------------------
`ifndef PWM_DUTY_THRESHOLD_DEBOUNCE_DEFINES_SVH
`define PWM_DUTY_THRESHOLD_DEBOUNCE_DEFINES_SVH

// Checked on every rising edge outside reset.
`define PDTD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Checked on every rising edge, reset included.
`define PDTD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/pdtd_pkg.sv */
// -----------------------------------------------------------------------------
// PWM duty threshold debounce package
// Widths, register indexes, reset values and shared types of the block.
// -----------------------------------------------------------------------------
package pdtd_pkg;

   localparam int NUM_CHANNELS = 4;

   localparam int PERIOD_W = 16;
   localparam int CHECKS_W = 8;
   localparam int THR_W    = 7;
   localparam int PROD_W   = 24;

   localparam int CSR_IDX_W  = $clog2(2 + NUM_CHANNELS);
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PERIOD = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_CHECKS = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD0 = CSR_IDX_W'(2);

   localparam logic [PERIOD_W-1:0] MIN_PERIOD_RST = PERIOD_W'(1000);
   localparam logic [CHECKS_W-1:0] MAX_CHECKS_RST = CHECKS_W'(3);
   localparam logic [THR_W-1:0]    THRESHOLD_RST  = THR_W'(50);
   localparam logic [CHECKS_W-1:0] COUNT_RST      = CHECKS_W'(1);

   localparam logic [PROD_W-1:0] DUTY_SCALE = PROD_W'(100);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic capture;
      logic update;
   } lane_ctl_type;

endpackage

/* design/pdtd_req_if.sv */
// -----------------------------------------------------------------------------
// PWM measurement request channel
// Valid/ready channel carrying the captured period and high time of each input.
// -----------------------------------------------------------------------------
interface pdtd_req_if import pdtd_pkg::*; ();

   logic                valid;
   logic                ready;
   logic [PERIOD_W-1:0] period_ch0;
   logic [PERIOD_W-1:0] high_ch0;
   logic [PERIOD_W-1:0] period_ch1;
   logic [PERIOD_W-1:0] high_ch1;
   logic [PERIOD_W-1:0] period_ch2;
   logic [PERIOD_W-1:0] high_ch2;
   logic [PERIOD_W-1:0] period_ch3;
   logic [PERIOD_W-1:0] high_ch3;

   modport source (
      output valid, period_ch0, high_ch0, period_ch1, high_ch1,
             period_ch2, high_ch2, period_ch3, high_ch3,
      input  ready
   );

   modport sink (
      input  valid, period_ch0, high_ch0, period_ch1, high_ch1,
             period_ch2, high_ch2, period_ch3, high_ch3,
      output ready
   );

endinterface

/* design/pdtd_rsp_if.sv */
// -----------------------------------------------------------------------------
// PWM flag response channel
// Valid/ready channel carrying the qualified state of each input.
// -----------------------------------------------------------------------------
interface pdtd_rsp_if;

   logic valid;
   logic ready;
   logic flag_ch0;
   logic flag_ch1;
   logic flag_ch2;
   logic flag_ch3;

   modport source (
      output valid, flag_ch0, flag_ch1, flag_ch2, flag_ch3,
      input  ready
   );

   modport sink (
      input  valid, flag_ch0, flag_ch1, flag_ch2, flag_ch3,
      output ready
   );

endinterface

/* design/pdtd_lane.sv */
// -----------------------------------------------------------------------------
// PWM duty threshold lane
// One channel: duty comparison by cross multiplication, then the debounce
// counter and the qualified flag.
// -----------------------------------------------------------------------------
module pdtd_lane import pdtd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  lane_ctl_type        lane_ctl,
   input  logic [PERIOD_W-1:0] period,
   input  logic [PERIOD_W-1:0] high,
   input  logic [PERIOD_W-1:0] min_period,
   input  logic [CHECKS_W-1:0] max_checks,
   input  logic [THR_W-1:0]    threshold,
   output logic                flag
);

   logic                eval_ff;
   logic                eval_in;
   logic [PROD_W-1:0]   lhs_ff;
   logic [PROD_W-1:0]   lhs_in;
   logic [PROD_W-1:0]   rhs_ff;
   logic [PROD_W-1:0]   rhs_in;
   logic [THR_W:0]      thr_inc;
   logic                sample;
   logic                flag_ff;
   logic                flag_in;
   logic [CHECKS_W-1:0] count_ff;
   logic [CHECKS_W-1:0] count_in;

   // The truncated percent exceeds the threshold exactly when
   // high * 100 >= (threshold + 1) * period, with the period nonzero.
   assign thr_inc = {1'b0, threshold} + (THR_W + 1)'(1);
   assign eval_in = period > min_period;
   assign lhs_in  = PROD_W'(high) * DUTY_SCALE;
   assign rhs_in  = PROD_W'(period) * PROD_W'(thr_inc);

   always_ff @(posedge clock) begin
      if (lane_ctl.capture) begin
         eval_ff <= eval_in;
         lhs_ff  <= lhs_in;
         rhs_ff  <= rhs_in;
      end
   end

   assign sample = lhs_ff >= rhs_ff;

   always_comb begin
      flag_in  = flag_ff;
      count_in = count_ff;
      if (lane_ctl.update && eval_ff) begin
         if (sample != flag_ff) begin
            if (count_ff == max_checks) begin
               count_in = '0;
               flag_in  = ~flag_ff;
            end else begin
               count_in = count_ff + CHECKS_W'(1);
            end
         end else begin
            count_in = COUNT_RST;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff  <= 1'b0;
         count_ff <= COUNT_RST;
      end else begin
         flag_ff  <= flag_in;
         count_ff <= count_in;
      end
   end

   assign flag = flag_ff;

endmodule

/* design/pdtd_ctrl.sv */
// -----------------------------------------------------------------------------
// PWM duty threshold sequencer and merge
// Steps each beat through capture, update and output, and gathers the lane
// flags into the response register.
// -----------------------------------------------------------------------------
module pdtd_ctrl import pdtd_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output lane_ctl_type            lane_ctl,
   input  logic [NUM_CHANNELS-1:0] lane_flags,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [NUM_CHANNELS-1:0] rsp_flags
);

   state_type               state_ff;
   state_type               state_in;
   logic                    out_free;
   logic                    out_load;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [NUM_CHANNELS-1:0] rsp_flags_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready        = 1'b0;
      lane_ctl.capture = 1'b0;
      lane_ctl.update  = 1'b0;
      out_load         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready        = 1'b1;
            lane_ctl.capture = req_valid;
         end
         ST_UPDATE: begin
            lane_ctl.update = 1'b1;
         end
         ST_OUT: begin
            out_load = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_flags_ff <= lane_flags;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_flags = rsp_flags_ff;

endmodule

/* design/pwm_duty_threshold_debounce.sv */
// -----------------------------------------------------------------------------
// PWM duty threshold debounce
// Four-lane duty percent threshold detector with a debounce counter per lane.
//
//   Channel   Direction  Beat
//   req_chan  in         period and high time of each PWM input
//   rsp_chan  out        qualified flag of each PWM input
//   csr_*     in         register write: min period, max checks, thresholds
//
// A beat is accepted in the cycle after the previous one left for the output
// register, and then passes through capture of the products, debounce update,
// and load of the response register. The response register is one deep;
// while it is held by a stalled sink, the next beat stops at the load step.
// Reset is synchronous and restores the registers, flags and counts.
// -----------------------------------------------------------------------------
module pwm_duty_threshold_debounce import pdtd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   pdtd_req_if.sink              req_chan,
   pdtd_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [PERIOD_W-1:0]     min_period_ff;
   logic [CHECKS_W-1:0]     max_checks_ff;
   logic [THR_W-1:0]        threshold_ff [NUM_CHANNELS];
   logic [PERIOD_W-1:0]     period [NUM_CHANNELS];
   logic [PERIOD_W-1:0]     high [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] lane_flags;
   logic [NUM_CHANNELS-1:0] rsp_flags;
   lane_ctl_type            lane_ctl;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_period_ff <= MIN_PERIOD_RST;
         max_checks_ff <= MAX_CHECKS_RST;
         for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            threshold_ff[ch] <= THRESHOLD_RST;
         end
      end else if (csr_we) begin
         if (csr_index == CSR_MIN_PERIOD) begin
            min_period_ff <= csr_wdata[PERIOD_W-1:0];
         end
         if (csr_index == CSR_MAX_CHECKS) begin
            max_checks_ff <= csr_wdata[CHECKS_W-1:0];
         end
         for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
            if (csr_index == CSR_THRESHOLD0 + CSR_IDX_W'(ch)) begin
               threshold_ff[ch] <= csr_wdata[THR_W-1:0];
            end
         end
      end
   end

   assign period[0] = req_chan.period_ch0;
   assign high[0]   = req_chan.high_ch0;
   assign period[1] = req_chan.period_ch1;
   assign high[1]   = req_chan.high_ch1;
   assign period[2] = req_chan.period_ch2;
   assign high[2]   = req_chan.high_ch2;
   assign period[3] = req_chan.period_ch3;
   assign high[3]   = req_chan.high_ch3;

   for (genvar ch = 0; ch < NUM_CHANNELS; ch++) begin : g_lane
      pdtd_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .lane_ctl   (lane_ctl),
         .period     (period[ch]),
         .high       (high[ch]),
         .min_period (min_period_ff),
         .max_checks (max_checks_ff),
         .threshold  (threshold_ff[ch]),
         .flag       (lane_flags[ch])
      );
   end

   pdtd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .lane_ctl   (lane_ctl),
      .lane_flags (lane_flags),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .rsp_flags  (rsp_flags)
   );

   assign rsp_chan.flag_ch0 = rsp_flags[0];
   assign rsp_chan.flag_ch1 = rsp_flags[1];
   assign rsp_chan.flag_ch2 = rsp_flags[2];
   assign rsp_chan.flag_ch3 = rsp_flags[3];

endmodule

/* design/pdtd_checker.sv */
// -----------------------------------------------------------------------------
// PWM duty threshold debounce checker
// Port-level properties of the block, attached to the top level by bind.
// -----------------------------------------------------------------------------
`include "pwm_duty_threshold_debounce_defines.svh"

module pdtd_checker import pdtd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   pdtd_req_if.sink   req_chan,
   pdtd_rsp_if.source rsp_chan
);

   // After an accepted beat the block is busy for the update and load steps.
   `PDTD_ASSERT(a_busy_after_accept, clock, reset, req_chan.valid && req_chan.ready |=> !req_chan.ready ##1 !req_chan.ready, "request accepted during busy steps")

   // A stalled response keeps its flags.
   `PDTD_ASSERT(a_rsp_hold, clock, reset, rsp_chan.valid && !rsp_chan.ready |=> rsp_chan.valid && $stable(rsp_chan.flag_ch0) && $stable(rsp_chan.flag_ch1) && $stable(rsp_chan.flag_ch2) && $stable(rsp_chan.flag_ch3), "stalled response changed")

   // Reset empties the response register.
   `PDTD_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_chan.valid, "response valid after reset")

endmodule

bind pwm_duty_threshold_debounce pdtd_checker u_pdtd_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);
